/* rtl/exyz_pkg.sv */
// Package for the Euler XYZ rotation matrix block: types, constants and tables.
`default_nettype none
package exyz_pkg;

    localparam int ANGLE_FRAC_BITS = 13;
    localparam int ELEM_FRAC_BITS  = 14;
    localparam int CORDIC_STEPS    = 16;

    // Internal fixed-point word: signed Q30 in 34 bits covers +-pi and gain growth.
    localparam int QW = 34;

    localparam logic signed [QW-1:0] Q30_ONE     = 34'sd1073741824;
    localparam logic signed [QW-1:0] Q30_PI      = 34'sd3373259426;
    localparam logic signed [QW-1:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [QW-1:0] CORDIC_GAIN = 34'sh026DD3B6A;

    typedef struct packed {
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
    } t_in;

    typedef struct packed {
        logic [1:0]         row_index;
        logic signed [15:0] elem_col0;
        logic signed [15:0] elem_col1;
        logic signed [15:0] elem_col2;
        logic signed [15:0] elem_col3;
        logic               last_row;
    } t_out;

    // Reduced angle request handed from the front end to the back end.
    typedef struct packed {
        logic signed [QW-1:0] z;
        logic                 flip;
    } t_ang;

    typedef struct packed {
        t_ang ax;
        t_ang ay;
        t_ang az;
    } t_req;

    function automatic logic signed [QW-1:0] atan_q30(input logic [4:0] i);
        logic signed [QW-1:0] v;
        begin
            case (i)
                5'd0:  v = 34'sh03243F6A8;
                5'd1:  v = 34'sh01DAC6705;
                5'd2:  v = 34'sh00FADBAFC;
                5'd3:  v = 34'sh007F56EA6;
                5'd4:  v = 34'sh003FEAB76;
                5'd5:  v = 34'sh001FFD55B;
                5'd6:  v = 34'sh000FFFAAA;
                5'd7:  v = 34'sh0007FFF55;
                5'd8:  v = 34'sh0003FFFEA;
                5'd9:  v = 34'sh0001FFFFD;
                5'd10: v = 34'sh0000FFFFF;
                5'd11: v = 34'sh00007FFFF;
                5'd12: v = 34'sh00003FFFF;
                5'd13: v = 34'sh00001FFFF;
                5'd14: v = 34'sh00000FFFF;
                5'd15: v = 34'sh000007FFF;
                5'd16: v = 34'sh000003FFF;
                5'd17: v = 34'sh000001FFF;
                5'd18: v = 34'sh000000FFF;
                5'd19: v = 34'sh0000007FF;
                5'd20: v = 34'sh0000003FF;
                5'd21: v = 34'sh0000001FF;
                5'd22: v = 34'sh0000000FF;
                5'd23: v = 34'sh00000007F;
                5'd24: v = 34'sh00000003F;
                5'd25: v = 34'sh00000001F;
                5'd26: v = 34'sh00000000F;
                5'd27: v = 34'sh000000008;
                5'd28: v = 34'sh000000004;
                5'd29: v = 34'sh000000002;
                5'd30: v = 34'sh000000001;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/exyz_front.sv */
// Front end: takes angle requests, clamps them and folds them into [-pi/2, pi/2].
`default_nettype none
module exyz_front #(
    parameter int ANGLE_FRAC_BITS = exyz_pkg::ANGLE_FRAC_BITS
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  exyz_pkg::t_in    i_data,
    output logic             o_valid,
    input  wire              i_ready,
    output exyz_pkg::t_req   o_req
);
    localparam int SH = 30 - ANGLE_FRAC_BITS;

    logic           r_valid;
    exyz_pkg::t_req r_req;
    exyz_pkg::t_req n_req;

    // Clamp one angle to [-pi, pi] and fold it into the CORDIC range.
    function automatic exyz_pkg::t_ang reduce(input logic signed [15:0] a);
        logic signed [exyz_pkg::QW-1:0] z;
        exyz_pkg::t_ang r;
        begin
            z = exyz_pkg::QW'(a) <<< SH;
            if (z > exyz_pkg::Q30_PI) z = exyz_pkg::Q30_PI;
            if (z < -exyz_pkg::Q30_PI) z = -exyz_pkg::Q30_PI;
            r.flip = 1'b0;
            if (z > exyz_pkg::Q30_HALF_PI) begin
                z = z - exyz_pkg::Q30_PI;
                r.flip = 1'b1;
            end else if (z < -exyz_pkg::Q30_HALF_PI) begin
                z = z + exyz_pkg::Q30_PI;
                r.flip = 1'b1;
            end
            r.z = z;
            return r;
        end
    endfunction

    always_comb begin
        n_req.ax = reduce(i_data.angle_x);
        n_req.ay = reduce(i_data.angle_y);
        n_req.az = reduce(i_data.angle_z);
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    // One-deep output register toward the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_req <= n_req;
        end
    end
endmodule
`default_nettype wire

/* rtl/exyz_fifo.sv */
// Small request queue between the front end and the back end.
`default_nettype none
module exyz_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  wire [WIDTH-1:0]  i_data,
    output logic             o_valid,
    input  wire              i_ready,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [AW:0]      r_cnt;
    logic             wr;
    logic             rd;

    assign o_ready = r_cnt != (AW+1)'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    // Pointers wrap at the depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (rd) r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
        end
        if (wr) r_mem[r_wp] <= i_data;
    end

    // The count never exceeds the depth, stays empty without a push and rises on a push without a pop.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH))
        else $error("queue count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 && !wr) |=> r_cnt == '0)
        else $error("queue count changed without push");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr && !rd) |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("queue count missed a push");
endmodule
`default_nettype wire

/* rtl/exyz_back.sv */
// Back end: pipelined CORDIC, two matrix products and row serialization.
`default_nettype none
module exyz_back #(
    parameter int ELEM_FRAC_BITS = exyz_pkg::ELEM_FRAC_BITS,
    parameter int CORDIC_STEPS   = exyz_pkg::CORDIC_STEPS
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  exyz_pkg::t_req   i_req,
    output logic             o_valid,
    input  wire              i_ready,
    output exyz_pkg::t_out   o_data
);
    localparam int QW = exyz_pkg::QW;
    localparam int NS = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
    localparam int NP = NS + 4; // CORDIC, Rx*Ry products, rounding, T*Rz products, sums
    localparam int PW = 2 * QW;

    typedef logic signed [QW-1:0] t_q;

    // Pipeline advances as a whole; it holds while the last stage still has rows to send.
    logic adv;
    logic [1:0] r_row;
    logic [NP-1:0] r_v;

    // Reduced angles of the incoming request feed the first CORDIC stage.
    t_q   z0 [3];
    logic f0 [3];

    // CORDIC stage registers, three lanes.
    t_q   r_x [3][1:NS];
    t_q   r_y [3][1:NS];
    t_q   r_z [3][1:NS];
    logic r_f [3][1:NS];

    assign adv = !r_v[NP-1] || (i_ready && r_row == 2'd3);
    assign o_ready = adv;

    assign z0[0] = i_req.ax.z;
    assign z0[1] = i_req.ay.z;
    assign z0[2] = i_req.az.z;
    assign f0[0] = i_req.ax.flip;
    assign f0[1] = i_req.ay.flip;
    assign f0[2] = i_req.az.flip;

    // One CORDIC iteration per stage.
    for (genvar s = 0; s < NS; s++) begin : g_cs
        for (genvar l = 0; l < 3; l++) begin : g_l
            t_q   x_i;
            t_q   y_i;
            t_q   z_i;
            logic f_i;
            if (s == 0) begin : g_src
                assign x_i = exyz_pkg::CORDIC_GAIN;
                assign y_i = '0;
                assign z_i = z0[l];
                assign f_i = f0[l];
            end else begin : g_src
                assign x_i = r_x[l][s];
                assign y_i = r_y[l][s];
                assign z_i = r_z[l][s];
                assign f_i = r_f[l][s];
            end
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    if (z_i >= 0) begin
                        r_x[l][s+1] <= x_i - (y_i >>> s);
                        r_y[l][s+1] <= y_i + (x_i >>> s);
                        r_z[l][s+1] <= z_i - exyz_pkg::atan_q30(5'(s));
                    end else begin
                        r_x[l][s+1] <= x_i + (y_i >>> s);
                        r_y[l][s+1] <= y_i - (x_i >>> s);
                        r_z[l][s+1] <= z_i + exyz_pkg::atan_q30(5'(s));
                    end
                    r_f[l][s+1] <= f_i;
                end
            end
        end
    end

    t_q cx, sx, cy, sy, cz, sz;
    assign cx = r_f[0][NS] ? -r_x[0][NS] : r_x[0][NS];
    assign sx = r_f[0][NS] ? -r_y[0][NS] : r_y[0][NS];
    assign cy = r_f[1][NS] ? -r_x[1][NS] : r_x[1][NS];
    assign sy = r_f[1][NS] ? -r_y[1][NS] : r_y[1][NS];
    assign cz = r_f[2][NS] ? -r_x[2][NS] : r_x[2][NS];
    assign sz = r_f[2][NS] ? -r_y[2][NS] : r_y[2][NS];

    function automatic t_q rnd(input logic signed [PW:0] acc);
        logic signed [PW:0] t;
        begin
            t = (acc + (PW+1)'(64'sd536870912)) >>> 30;
            return t[QW-1:0];
        end
    endfunction

    // Rx*Ry: products registered, then rounded.
    logic signed [PW-1:0] r_p1 [4];
    t_q r_t [4]; // single-term elements: cy, -sy, cx, sx
    t_q r_czs, r_szs, r_cz2, r_sz2;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1[0] <= sx * sy;  // t10
            r_p1[1] <= sx * cy;  // t12
            r_p1[2] <= cx * sy;  // t20
            r_p1[3] <= cx * cy;  // t22
            r_t[0] <= cy;
            r_t[1] <= -sy;
            r_t[2] <= cx;
            r_t[3] <= sx;
            r_czs <= cz;
            r_szs <= sz;
        end
    end

    // T = [cy 0 -sy; sx*sy cx sx*cy; cx*sy -sx cx*cy] after rounding.
    t_q r_m [3][3];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m[0][0] <= rnd((PW+1)'(r_t[0]) <<< 30);
            r_m[0][1] <= '0;
            r_m[0][2] <= rnd((PW+1)'(r_t[1]) <<< 30);
            r_m[1][0] <= rnd((PW+1)'(r_p1[0]));
            r_m[1][1] <= rnd((PW+1)'(r_t[2]) <<< 30);
            r_m[1][2] <= rnd((PW+1)'(r_p1[1]));
            r_m[2][0] <= rnd((PW+1)'(r_p1[2]));
            r_m[2][1] <= rnd(-((PW+1)'(r_t[3]) <<< 30));
            r_m[2][2] <= rnd((PW+1)'(r_p1[3]));
            r_cz2 <= r_czs;
            r_sz2 <= r_szs;
        end
    end

    // T*Rz: col0 = t0*cz - t1*sz, col1 = t0*sz + t1*cz, col2 = t2.
    logic signed [PW-1:0] r_q [3][4];
    t_q r_c2 [3];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_q[i][0] <= r_m[i][0] * r_cz2;
                r_q[i][1] <= r_m[i][1] * r_sz2;
                r_q[i][2] <= r_m[i][0] * r_sz2;
                r_q[i][3] <= r_m[i][1] * r_cz2;
                r_c2[i]   <= r_m[i][2];
            end
        end
    end

    function automatic logic signed [15:0] to_out(input t_q v);
        localparam int SHO = 30 - ELEM_FRAC_BITS;
        logic signed [QW:0] r;
        logic signed [QW:0] lim;
        begin
            lim = (QW+1)'(1) <<< ELEM_FRAC_BITS;
            if (SHO > 0) r = ((QW+1)'(v) + ((QW+1)'(1) <<< (SHO > 0 ? SHO-1 : 0))) >>> SHO;
            else r = (QW+1)'(v);
            if (r > lim) r = lim;
            if (r < -lim) r = -lim;
            if (r > (QW+1)'(32767)) r = (QW+1)'(32767);
            if (r < -(QW+1)'(32768)) r = -(QW+1)'(32768);
            return r[15:0];
        end
    endfunction

    // Final rounding and format conversion, all three rows at once.
    logic signed [15:0] r_e [3][3];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_e[i][0] <= to_out(rnd((PW+1)'(r_q[i][0]) - (PW+1)'(r_q[i][1])));
                r_e[i][1] <= to_out(rnd((PW+1)'(r_q[i][2]) + (PW+1)'(r_q[i][3])));
                r_e[i][2] <= to_out(rnd((PW+1)'(r_c2[i]) <<< 30));
            end
        end
    end

    // Valid pipeline; the last bit marks a finished matrix in the output stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[NP-2:0], i_valid};
        end
    end

    // Row counter: steps through the four rows of the matrix held in the last stage.
    logic signed [15:0] one_e;
    assign one_e = to_out(exyz_pkg::Q30_ONE);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else if (r_v[NP-1] && i_ready) begin
            r_row <= r_row + 1'b1;
        end
    end

    assign o_valid = r_v[NP-1];
    always_comb begin
        o_data.row_index = r_row;
        o_data.last_row  = r_row == 2'd3;
        if (r_row == 2'd3) begin
            o_data.elem_col0 = '0;
            o_data.elem_col1 = '0;
            o_data.elem_col2 = '0;
            o_data.elem_col3 = one_e;
        end else begin
            o_data.elem_col0 = r_e[r_row][0];
            o_data.elem_col1 = r_e[r_row][1];
            o_data.elem_col2 = r_e[r_row][2];
            o_data.elem_col3 = '0;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(r_row)))
        else $error("row advanced while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready) |=> r_row == $past(r_row) + 1'b1)
        else $error("row sequence skipped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_row != 2'd3) |-> !adv)
        else $error("pipeline moved during row output");
endmodule
`default_nettype wire

/* rtl/euler_xyz_rotation_matrix.sv */
// Top level of the Euler XYZ rotation matrix generator.
// A request passes the front register, the queue, the CORDIC and the product stages.
// Each request yields four rows on the one output port, which limits the request rate.
// The CORDIC and product pipeline holds while the row sequencer emits a matrix.
// Reset is synchronous, active low, and empties the queue and all valid flags.
`default_nettype none
module euler_xyz_rotation_matrix #(
    parameter int ANGLE_FRAC_BITS = exyz_pkg::ANGLE_FRAC_BITS,
    parameter int ELEM_FRAC_BITS  = exyz_pkg::ELEM_FRAC_BITS,
    parameter int CORDIC_STEPS    = exyz_pkg::CORDIC_STEPS
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  exyz_pkg::t_in    i_data,
    output logic             o_valid,
    input  wire              i_ready,
    output exyz_pkg::t_out   o_data
);
    logic           f_valid, f_ready, q_valid, q_ready;
    exyz_pkg::t_req f_req, q_req;

    exyz_front #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_data,
        .o_valid(f_valid), .i_ready(f_ready), .o_req(f_req)
    );

    exyz_fifo #(.WIDTH($bits(exyz_pkg::t_req)), .DEPTH(2)) u_fifo (
        .i_clk, .i_rst_n, .i_valid(f_valid), .o_ready(f_ready), .i_data(f_req),
        .o_valid(q_valid), .i_ready(q_ready), .o_data(q_req)
    );

    exyz_back #(.ELEM_FRAC_BITS(ELEM_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .o_ready(q_ready), .i_req(q_req),
        .o_valid, .i_ready, .o_data
    );
endmodule
`default_nettype wire
